/* rtl/fea_pkg.sv */
// Shared types, codes and byte decode for the fraction expression adder.
package fea_pkg;

  // Default value width and fixed result field widths
  localparam int FEA_VALUE_BITS = 32;
  localparam int SUM_NUM_W = 32;
  localparam int SUM_DEN_W = 31;

  // Expression characters
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_SLASH = 8'h2F;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    SYM_OTHER,
    SYM_DIGIT,
    SYM_SLASH,
    SYM_PLUS,
    SYM_MINUS
  } sym_class_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NONE,
    DP_APPLY,
    DP_LOAD_FIRST,
    DP_MUL_START,
    DP_MUL_STEP,
    DP_ADDSUB,
    DP_GCD_STEP,
    DP_GSHIFT,
    DP_DIV_STEP,
    DP_WRITE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   term_clear;  // zero the term registers
    logic   term_open;   // open a new term (with term_clear)
    logic   term_neg;    // sign of the newly opened term
  } dp_cmd_t;

  typedef struct packed {
    logic term_open;
    logic have_sum;
    logic mul_done;
    logic gcd_done;
    logic div_done;
    logic mag_zero;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_ADDSUB,
    ST_GCD,
    ST_GSHIFT,
    ST_DIV,
    ST_WRITE,
    ST_EMIT
  } fea_state_t;

  function automatic sym_class_t sym_class(input logic [7:0] s);
    sym_class_t c;
    c = SYM_OTHER;
    if (s inside {[ASCII_ZERO:ASCII_NINE]}) begin
      c = SYM_DIGIT;
    end else begin
      case (s)
        ASCII_SLASH: c = SYM_SLASH;
        ASCII_PLUS:  c = SYM_PLUS;
        ASCII_MINUS: c = SYM_MINUS;
        default:     c = SYM_OTHER;
      endcase
    end
    return c;
  endfunction

endpackage

/* rtl/fea_dpath.sv */
// Datapath: term parsing, shift-add multipliers, binary gcd, restoring dividers, sum registers.
module fea_dpath
  import fea_pkg::*;
#(
  parameter int VALUE_BITS = FEA_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  symbol,
  input  dp_cmd_t                     cmd,
  output dp_stat_t                    stat,
  output logic signed [SUM_NUM_W-1:0] sum_num,
  output logic [SUM_DEN_W-1:0]        sum_den,
  output logic                        overflow
);

  localparam int VB = VALUE_BITS;
  localparam int PW = 2 * VB;
  localparam int IW = (PW > 64) ? 64 : PW;
  localparam int CW = $clog2(IW + 1);
  localparam int KW = $clog2(IW);
  localparam logic [VB-1:0] MAX_MAG = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] NUM_MAX = {1'b1, {(VB-1){1'b0}}};
  localparam logic [CW-1:0] MUL_LAST = CW'(VB - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(IW - 1);

  // One shift-add multiply step: multiplier in low half, product grows from the top
  function automatic logic [PW-1:0] mstep(input logic [PW-1:0] p, input logic [VB-1:0] m);
    logic [VB:0] s;
    s = {1'b0, p[PW-1:VB]} + (p[0] ? {1'b0, m} : {(VB+1){1'b0}});
    return {s, p[VB-1:1]};
  endfunction

  // Saturate a full product to the working width
  function automatic logic [IW-1:0] sat_iw(input logic [PW-1:0] p);
    return ((p >> IW) != '0) ? {IW{1'b1}} : p[IW-1:0];
  endfunction

  // One restoring divide step: returns {remainder, quotient}
  function automatic logic [2*IW-1:0] dstep(input logic [IW-1:0] r, input logic [IW-1:0] q,
                                            input logic [IW-1:0] d);
    logic [IW:0] t;
    logic [IW:0] s;
    logic        qb;
    t  = {r, q[IW-1]};
    qb = t >= {1'b0, d};
    s  = qb ? (t - {1'b0, d}) : t;
    return {s[IW-1:0], q[IW-2:0], qb};
  endfunction

  // Expression state
  logic          term_negative;
  logic [VB-1:0] term_num;
  logic [VB-2:0] term_den;
  logic          after_slash;
  logic          term_open;
  logic          have_sum;
  logic [VB-1:0] acc_num;
  logic [VB-2:0] acc_den;
  logic          ovf;

  // Fold working registers
  logic [PW-1:0] pa, pb, pc;
  logic [IW-1:0] fmag, fden;
  logic          fneg;
  logic [IW-1:0] ga, gb;
  logic [KW-1:0] gk;
  logic [IW-1:0] gdiv;
  logic [IW-1:0] qm, qd, rm, rd;
  logic [CW-1:0] cnt;

  // Digit accumulate with saturation
  sym_class_t      cls;
  logic [3:0]      digit;
  logic [VB-1:0]   dig_cur, dig_lim, dig_val;
  logic [VB+3:0]   dig_new;
  logic            dig_ovf;

  always_comb begin
    cls     = sym_class(symbol);
    digit   = 4'(symbol - ASCII_ZERO);
    dig_cur = after_slash ? {1'b0, term_den} : term_num;
    dig_lim = after_slash ? MAX_MAG : (MAX_MAG + VB'(term_negative));
    dig_new = (VB+4)'({dig_cur, 3'b000}) + (VB+4)'({dig_cur, 1'b0}) + (VB+4)'(digit);
    dig_ovf = dig_new > (VB+4)'(dig_lim);
    dig_val = dig_ovf ? dig_lim : dig_new[VB-1:0];
  end

  // Cross-multiplied sum or difference of the two magnitudes
  logic [VB-1:0] acc_mag;
  logic [IW-1:0] p1, p2, pd, as_mag;
  logic [IW:0]   as_sum;
  logic          as_neg, as_ovf;

  always_comb begin
    acc_mag = acc_num[VB-1] ? (~acc_num + VB'(1)) : acc_num;
    p1      = sat_iw(pa);
    p2      = sat_iw(pb);
    pd      = sat_iw(pc);
    as_sum  = {1'b0, p1} + {1'b0, p2};
    as_ovf  = ((pa >> IW) != '0) || ((pb >> IW) != '0) || ((pc >> IW) != '0);
    if (acc_num[VB-1] == term_negative) begin
      as_mag = as_sum[IW] ? {IW{1'b1}} : as_sum[IW-1:0];
      as_neg = acc_num[VB-1];
      as_ovf = as_ovf || as_sum[IW];
    end else if (p1 >= p2) begin
      as_mag = p1 - p2;
      as_neg = acc_num[VB-1];
    end else begin
      as_mag = p2 - p1;
      as_neg = term_negative;
    end
  end

  // Clamp into the stored ranges; shared by first-term load and fold write
  logic          cl_neg, cl_mag_ovf, cl_den_ovf;
  logic [IW-1:0] cl_mag, cl_den, cl_lim, cl_mag_c, cl_den_c;
  logic [VB-1:0] cl_num;

  always_comb begin
    if (cmd.op == DP_LOAD_FIRST) begin
      cl_neg = term_negative;
      cl_mag = IW'(term_num);
      cl_den = IW'(term_den);
    end else begin
      cl_neg = fneg;
      cl_mag = qm;
      cl_den = qd;
    end
    cl_lim     = IW'(MAX_MAG) + IW'(cl_neg);
    cl_mag_ovf = cl_mag > cl_lim;
    cl_mag_c   = cl_mag_ovf ? cl_lim : cl_mag;
    cl_den_ovf = cl_den > IW'(MAX_MAG);
    cl_den_c   = cl_den_ovf ? IW'(MAX_MAG) : cl_den;
    cl_num     = cl_neg ? (~cl_mag_c[VB-1:0] + VB'(1)) : cl_mag_c[VB-1:0];
  end

  // Result view of the sum, extended then cut to the port widths
  logic [63:0] acc_ext, den_ext;
  assign acc_ext = 64'($signed(acc_num));
  assign den_ext = 64'(acc_den);

  // Expression state registers
  always_ff @(posedge clk) begin
    if (rst || cmd.op == DP_EMIT) begin
      term_negative <= 1'b0;
      term_num      <= '0;
      term_den      <= '0;
      after_slash   <= 1'b0;
      term_open     <= 1'b0;
      have_sum      <= 1'b0;
      acc_num       <= '0;
      acc_den       <= (VB-1)'(1);
      ovf           <= 1'b0;
    end else begin
      case (cmd.op)
        DP_APPLY: begin
          if (cls == SYM_SLASH) begin
            term_open   <= 1'b1;
            after_slash <= 1'b1;
          end else if (cls == SYM_DIGIT) begin
            term_open <= 1'b1;
            ovf       <= ovf | dig_ovf;
            if (after_slash) begin
              term_den <= dig_val[VB-2:0];
            end else begin
              term_num <= dig_val;
            end
          end
        end
        DP_ADDSUB: ovf <= ovf | as_ovf;
        DP_LOAD_FIRST, DP_WRITE: begin
          have_sum <= 1'b1;
          if (cmd.op == DP_WRITE && fmag == '0) begin
            acc_num <= '0;
            acc_den <= (VB-1)'(1);
          end else begin
            acc_num <= cl_num;
            acc_den <= cl_den_c[VB-2:0];
            ovf     <= ovf | cl_mag_ovf | cl_den_ovf;
          end
        end
        default: ;
      endcase
      if (cmd.term_clear) begin
        term_num      <= '0;
        term_den      <= '0;
        after_slash   <= 1'b0;
        term_open     <= cmd.term_open;
        term_negative <= cmd.term_neg;
      end
    end
  end

  // Fold working registers and step counter
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_MUL_START: begin
        pa  <= {{VB{1'b0}}, 1'b0, term_den};
        pb  <= {{VB{1'b0}}, 1'b0, acc_den};
        pc  <= {{VB{1'b0}}, 1'b0, term_den};
        cnt <= '0;
      end
      DP_MUL_STEP: begin
        pa  <= mstep(pa, acc_mag);
        pb  <= mstep(pb, term_num);
        pc  <= mstep(pc, {1'b0, acc_den});
        cnt <= cnt + CW'(1);
      end
      DP_ADDSUB: begin
        fmag <= as_mag;
        fden <= pd;
        fneg <= as_neg;
        ga   <= pd;
        gb   <= as_mag;
        gk   <= '0;
      end
      DP_GCD_STEP: begin
        if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          gk <= gk + KW'(1);
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga >= gb) begin
          ga <= ga - gb;
        end else begin
          gb <= gb - ga;
        end
      end
      DP_GSHIFT: begin
        gdiv <= (ga | gb) << gk;
        qm   <= fmag;
        qd   <= fden;
        rm   <= '0;
        rd   <= '0;
        cnt  <= '0;
      end
      DP_DIV_STEP: begin
        {rm, qm} <= dstep(rm, qm, gdiv);
        {rd, qd} <= dstep(rd, qd, gdiv);
        cnt      <= cnt + CW'(1);
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.op == DP_EMIT) begin
      sum_num  <= have_sum ? $signed(acc_ext[SUM_NUM_W-1:0]) : '0;
      sum_den  <= have_sum ? den_ext[SUM_DEN_W-1:0] : SUM_DEN_W'(1);
      overflow <= ovf;
    end
  end

  // Status to the controller
  always_comb begin
    stat.term_open = term_open;
    stat.have_sum  = have_sum;
    stat.mul_done  = cnt == MUL_LAST;
    stat.gcd_done  = (ga == '0) || (gb == '0);
    stat.div_done  = cnt == DIV_LAST;
    stat.mag_zero  = fmag == '0;
  end

`ifndef SYNTHESIS
  // The divider only runs on a nonzero gcd
  assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_DIV_STEP |-> gdiv != '0)
    else $error("divide step with zero divisor");

  // Digit saturation keeps the numerator within the negative bound
  assert property (@(posedge clk) disable iff (rst)
    term_num <= NUM_MAX)
    else $error("term numerator out of range");

  // A completed fold always leaves a running sum
  assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_WRITE |=> have_sum)
    else $error("fold write without running sum");
`endif

endmodule

/* rtl/fea_ctrl.sv */
// Controller: accepts bytes, sequences each term fold and emits the result beat.
module fea_ctrl
  import fea_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] symbol,
  input  logic       is_last,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  fea_state_t state, state_next;
  logic       pend_sign, pend_sign_next;
  logic       pend_neg, pend_neg_next;
  logic       pend_last, pend_last_next;
  logic       out_valid_next;
  logic       fold_end;
  sym_class_t cls;

  // State and handshake registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend_sign <= 1'b0;
      pend_neg  <= 1'b0;
      pend_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend_sign <= pend_sign_next;
      pend_neg  <= pend_neg_next;
      pend_last <= pend_last_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    cls            = sym_class(symbol);
    state_next     = state;
    pend_sign_next = pend_sign;
    pend_neg_next  = pend_neg;
    pend_last_next = pend_last;
    out_valid_next = out_valid && out_stall;
    in_stall       = state != ST_IDLE;
    fold_end       = 1'b0;
    cmd.op         = DP_NONE;
    cmd.term_clear = 1'b0;
    cmd.term_open  = 1'b0;
    cmd.term_neg   = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op         = DP_APPLY;
          pend_sign_next = (cls == SYM_PLUS) || (cls == SYM_MINUS);
          pend_neg_next  = cls == SYM_MINUS;
          pend_last_next = is_last;
          if (cls == SYM_PLUS || cls == SYM_MINUS || is_last) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // no open term: nothing to fold; first term: load as is
        if (!stat.term_open) begin
          fold_end = 1'b1;
        end else if (!stat.have_sum) begin
          cmd.op         = DP_LOAD_FIRST;
          cmd.term_clear = 1'b1;
          fold_end       = 1'b1;
        end else begin
          cmd.op     = DP_MUL_START;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.op = DP_MUL_STEP;
        if (stat.mul_done) begin
          state_next = ST_ADDSUB;
        end
      end
      ST_ADDSUB: begin
        cmd.op     = DP_ADDSUB;
        state_next = ST_GCD;
      end
      ST_GCD: begin
        if (stat.gcd_done) begin
          state_next = ST_GSHIFT;
        end else begin
          cmd.op = DP_GCD_STEP;
        end
      end
      ST_GSHIFT: begin
        cmd.op     = DP_GSHIFT;
        state_next = stat.mag_zero ? ST_WRITE : ST_DIV;
      end
      ST_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (stat.div_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.op         = DP_WRITE;
        cmd.term_clear = 1'b1;
        fold_end       = 1'b1;
      end
      ST_EMIT: begin
        // result register frees up this cycle or is already empty
        if (!out_valid || !out_stall) begin
          cmd.op         = DP_EMIT;
          out_valid_next = 1'b1;
          pend_last_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // After a fold: open the signed term, then fold again or emit on the last byte
    if (fold_end) begin
      if (pend_sign) begin
        cmd.term_clear = 1'b1;
        cmd.term_open  = 1'b1;
        cmd.term_neg   = pend_neg;
        pend_sign_next = 1'b0;
        state_next     = pend_last ? ST_CHECK : ST_IDLE;
      end else begin
        state_next = ST_EMIT;
      end
    end
  end

`ifndef SYNTHESIS
  // A sign byte is always consumed before new bytes are taken
  assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_sign && !pend_last)
    else $error("pending byte work left in idle");

  // A result beat only appears out of the emit state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result beat raised outside emit");
`endif

endmodule

/* rtl/fraction_expression_adder.sv */
// Top level: fraction expression adder, one expression byte per input beat.
// Digits, '/' and other bytes are taken directly; '+', '-' or the last byte add a check state.
// A fold of a later term runs the shift-add multiply, an add step, the binary gcd, a shift step
// and the restoring divide over W bits (W = min(2*VALUE_BITS, 64)), then a write step.
// The result beat is registered out of the emit state; synchronous reset clears the sum to 0/1.
module fraction_expression_adder
  import fea_pkg::*;
#(
  parameter int VALUE_BITS = FEA_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  symbol,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SUM_NUM_W-1:0] sum_num,
  output logic [SUM_DEN_W-1:0]        sum_den,
  output logic                        overflow
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .symbol    (symbol),
    .is_last   (is_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fea_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .symbol   (symbol),
    .cmd      (cmd),
    .stat     (stat),
    .sum_num  (sum_num),
    .sum_den  (sum_den),
    .overflow (overflow)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for fraction_expression_adder: expression beats in, reduced sums out.
`timescale 1ns / 100ps

module tb_top
  import fea_pkg::*;
;

  localparam bit [63:0] MAG_MAX = (64'd1 << (FEA_VALUE_BITS - 1)) - 64'd1;
  localparam int        N_ITEMS = 1550;
  localparam int        HOLD_OFF = 400;

  // One expected sum as it leaves the block
  typedef struct {
    logic signed [SUM_NUM_W-1:0] num;
    logic [SUM_DEN_W-1:0]        den;
    logic                        ovf;
  } frac_t;

  // One input beat waiting to be offered
  typedef struct {
    logic [7:0] sym;
    logic       last;
    int         gap;
    bit         drain;
  } sym_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] symbol = 8'h00;
  logic is_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SUM_NUM_W-1:0] sum_num;
  logic [SUM_DEN_W-1:0] sum_den;
  logic overflow;

  sym_beat_t  pending[$];
  frac_t      sums_due[$];
  logic [7:0] expr_bytes[$];

  int  mismatches = 0;
  int  sums_seen = 0;
  int  useful_beats = 0;
  int  gap_cnt = 0;
  int  hold_cnt = 0;
  bit  calm = 0;
  bit  drain_next = 0;

  // Sum tracker state
  bit        t_neg, t_slash, t_open, s_valid, ovf_seen;
  bit [63:0] t_num, t_den, s_num, s_den;

  fraction_expression_adder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .symbol(symbol),
    .is_last(is_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sum_num(sum_num),
    .sum_den(sum_den),
    .overflow(overflow)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- sum tracker
  function automatic bit [63:0] num_ceiling(input bit neg);
    return MAG_MAX + (neg ? 64'd1 : 64'd0);
  endfunction

  function automatic bit [63:0] sat_mul(input bit [63:0] a, input bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] != 0) begin
      ovf_seen = 1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic bit [63:0] sat_add(input bit [63:0] a, input bit [63:0] b);
    bit [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      ovf_seen = 1;
      return '1;
    end
    return s[63:0];
  endfunction

  function automatic bit [63:0] clip(input bit [63:0] v, input bit [63:0] lim);
    if (v > lim) begin
      ovf_seen = 1;
      return lim;
    end
    return v;
  endfunction

  function automatic bit [63:0] euclid(input bit [63:0] a, input bit [63:0] b);
    bit [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic void load_sum(input bit neg, input bit [63:0] mag, input bit [63:0] den);
    mag = clip(mag, num_ceiling(neg));
    s_num = neg ? (64'd0 - mag) : mag;
    s_den = clip(den, MAG_MAX);
  endfunction

  function automatic void clear_term();
    t_neg = 0;
    t_num = 0;
    t_den = 0;
    t_slash = 0;
    t_open = 0;
  endfunction

  // Close the open term into the running sum
  function automatic void fold_term();
    bit        an, neg;
    bit [63:0] am, p1, p2, den, mag, g;
    if (!t_open) return;
    if (!s_valid) begin
      // first term goes in as written, unreduced
      load_sum(t_neg, t_num, t_den);
      s_valid = 1;
    end else begin
      an = s_num[63];
      am = an ? (64'd0 - s_num) : s_num;
      p1 = sat_mul(am, t_den);
      p2 = sat_mul(t_num, s_den);
      den = sat_mul(s_den, t_den);
      if (an == t_neg) begin
        mag = sat_add(p1, p2);
        neg = an;
      end else if (p1 >= p2) begin
        mag = p1 - p2;
        neg = an;
      end else begin
        mag = p2 - p1;
        neg = t_neg;
      end
      if (mag == 0) begin
        s_num = 0;
        s_den = 1;
      end else begin
        g = euclid(den, mag);
        load_sum(neg, mag / g, den / g);
      end
    end
    clear_term();
  endfunction

  function automatic bit [63:0] shift_in_digit(input bit [63:0] v, input bit [63:0] d,
                                               input bit [63:0] lim);
    if (v > (lim - d) / 64'd10) begin
      ovf_seen = 1;
      return lim;
    end
    return v * 64'd10 + d;
  endfunction

  // Advance the tracker by one accepted beat; queue a sum on the final byte
  function automatic void track_beat(input logic [7:0] sym, input logic last);
    bit [63:0] dig, lim;
    frac_t     r;
    if (sym == ASCII_PLUS || sym == ASCII_MINUS) begin
      fold_term();
      t_open = 1;
      t_neg = (sym == ASCII_MINUS);
    end else if (sym == ASCII_SLASH) begin
      t_open = 1;
      t_slash = 1;
    end else if (sym >= ASCII_ZERO && sym <= ASCII_NINE) begin
      dig = 64'(sym - ASCII_ZERO);
      lim = t_slash ? MAG_MAX : num_ceiling(t_neg);
      t_open = 1;
      if (t_slash) t_den = shift_in_digit(t_den, dig, lim);
      else t_num = shift_in_digit(t_num, dig, lim);
    end
    if (!last) return;
    fold_term();
    if (s_valid) begin
      r.num = s_num[SUM_NUM_W-1:0];
      r.den = s_den[SUM_DEN_W-1:0];
    end else begin
      // empty expression
      r.num = 0;
      r.den = 1;
    end
    r.ovf = ovf_seen;
    sums_due.insert(sums_due.size(), r);
    clear_term();
    s_valid = 0;
    s_num = 0;
    s_den = 1;
    ovf_seen = 0;
  endfunction

  // ---------------------------------------------------------------- stimulus build
  function automatic void push_beat(input logic [7:0] sym, input logic last);
    sym_beat_t b;
    b.sym = sym;
    b.last = last;
    b.gap = calm ? 0 : $urandom_range(0, 11);
    b.drain = drain_next;
    drain_next = 0;
    pending.insert(pending.size(), b);
    if (sym_class(sym) != SYM_OTHER || last) useful_beats++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], i == s.len() - 1);
  endfunction

  // Append one byte, sometimes preceded by a stray byte
  function automatic void add_sym(input logic [7:0] b);
    if ($urandom_range(0, 99) < 3)
      expr_bytes.insert(expr_bytes.size(), 8'($urandom_range(0, 255)));
    expr_bytes.insert(expr_bytes.size(), b);
  endfunction

  function automatic void add_digits(input int n, input bit nonzero_lead);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && nonzero_lead) add_sym(ASCII_ZERO + 8'($urandom_range(1, 9)));
      else add_sym(ASCII_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic int draw_len(input int r, input int none_pct, input int long_pct);
    if (r < none_pct) return 0;
    if (r < none_pct + long_pct) return $urandom_range(5, 11);
    return $urandom_range(1, 2);
  endfunction

  // One random expression: mostly well-formed terms, some junk and odd shapes
  function automatic void random_expr();
    int kind, terms;
    expr_bytes.delete();
    calm = ($urandom_range(0, 5) == 0);
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      for (int i = $urandom_range(1, 4); i > 0; i--)
        expr_bytes.insert(expr_bytes.size(), 8'($urandom_range(0, 255)));
    end else if (kind < 9) begin
      // sign only, or a single random byte
      if ($urandom_range(0, 1)) add_sym($urandom_range(0, 1) ? ASCII_PLUS : ASCII_MINUS);
      else expr_bytes.insert(expr_bytes.size(), 8'($urandom_range(0, 255)));
    end else begin
      terms = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      for (int t = 0; t < terms; t++) begin
        if (t != 0 || $urandom_range(0, 1))
          add_sym($urandom_range(0, 1) ? ASCII_PLUS : ASCII_MINUS);
        add_digits(draw_len($urandom_range(0, 99), 4, 4), 0);
        if ($urandom_range(0, 99) < 92) begin
          add_sym(ASCII_SLASH);
          if ($urandom_range(0, 99) < 3) add_sym(ASCII_SLASH);
          add_digits(draw_len($urandom_range(0, 99), 3, 4), $urandom_range(0, 9) != 0);
        end
      end
      if (expr_bytes.size() == 0) expr_bytes.insert(0, 8'hFF);
    end
    foreach (expr_bytes[i]) push_beat(expr_bytes[i], i == expr_bytes.size() - 1);
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_valid && !in_stall) track_beat(symbol, is_last);
      // a stalled beat holds; otherwise offer the next one after its gap
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && gap_cnt >= pending[0].gap &&
            (!pending[0].drain || sums_due.size() == 0)) begin
          in_valid <= 1'b1;
          symbol <= pending[0].sym;
          is_last <= pending[0].last;
          void'(pending.pop_front());
          gap_cnt = 0;
        end else begin
          in_valid <= 1'b0;
          if (pending.size() != 0) gap_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_sum();
    frac_t want;
    if (sums_due.size() == 0) begin
      $display("%0t: unexpected sum beat num=%0d den=%0d ovf=%0b",
               $time, sum_num, sum_den, overflow);
      mismatches++;
      return;
    end
    want = sums_due.pop_front();
    if (sum_num !== want.num) begin
      $display("%0t: sum_num expected %0d actual %0d", $time, want.num, sum_num);
      mismatches++;
    end
    if (sum_den !== want.den) begin
      $display("%0t: sum_den expected %0d actual %0d", $time, want.den, sum_den);
      mismatches++;
    end
    if (overflow !== want.ovf) begin
      $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, overflow);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_sum();
        sums_seen++;
        // one long hold-off so the block backs up into its input
        if (sums_seen == 30) hold_cnt = HOLD_OFF;
        else if ((sums_seen / 40) % 3 == 1) hold_cnt = 0;
        else hold_cnt = $urandom_range(0, 11);
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      out_stall <= (hold_cnt > 0);
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int n_expr;
    clear_term();
    s_valid = 0;
    s_num = 0;
    s_den = 1;
    ovf_seen = 0;

    // directed: empty, mixed signs, sign alone, no slash, zero denominator, clamp
    push_beat(8'hFF, 1'b1);
    push_text("-1/2+1/3");
    push_text("-");
    push_beat(8'h00, 1'b0);
    push_text("5");
    push_text("7/0+1/2");
    push_text("-2147483649");

    n_expr = 0;
    while (useful_beats < N_ITEMS) begin
      // once, let every sum drain before the next expression goes in
      if (n_expr == 100) drain_next = 1;
      random_expr();
      n_expr++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid || sums_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (mismatches == 0 && sums_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(80_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
